/* hw/rtl/loop_switcher_preset_controller_defines.svh */
// ----------------------------------------------------------------------------
// Loop switcher preset controller assertion macros
// Immediate-edge and next-edge implication checks on clk, reset by rst_n.
// ----------------------------------------------------------------------------
`ifndef LOOP_SWITCHER_PRESET_CONTROLLER_DEFINES_SVH
`define LOOP_SWITCHER_PRESET_CONTROLLER_DEFINES_SVH

`ifndef NO_ASSERTIONS
// ante holds -> cons holds at the same edge
`define LSPC_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("lspc assertion failed");
// ante holds -> cons holds at the next edge
`define LSPC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("lspc assertion failed");
`else
`define LSPC_ASSERT_NOW(label, ante, cons)
`define LSPC_ASSERT_NEXT(label, ante, cons)
`endif

`endif

/* hw/rtl/lspc_pkg.sv */
// ----------------------------------------------------------------------------
// lspc_pkg
// Shared constants of the loop switcher preset controller.
// ----------------------------------------------------------------------------
package lspc_pkg;

  localparam int PRESET_COUNT = 3;
  localparam int LOOP_COUNT   = 4;

  // held button codes
  localparam logic [3:0] CODE_NONE        = 4'd0;
  localparam logic [3:0] CODE_UP          = 4'd1;
  localparam logic [3:0] CODE_DOWN        = 4'd2;
  localparam logic [3:0] CODE_PRESET0     = 4'd3;
  localparam logic [3:0] CODE_PRESET_LAST = 4'(3 + PRESET_COUNT - 1);
  localparam logic [3:0] CODE_LOOP0       = 4'(3 + PRESET_COUNT);
  localparam logic [3:0] CODE_LOOP_LAST   = 4'(3 + PRESET_COUNT + LOOP_COUNT - 1);

  // event codes
  localparam logic [1:0] EV_NONE = 2'd0;
  localparam logic [1:0] EV_LOAD = 2'd1;
  localparam logic [1:0] EV_SAVE = 2'd2;

  // configuration register indexes
  localparam logic [1:0] REG_DEBOUNCE   = 2'd0;
  localparam logic [1:0] REG_LONG_PRESS = 2'd1;

  localparam logic [15:0] DEBOUNCE_RESET   = 16'd50;
  localparam logic [15:0] LONG_PRESS_RESET = 16'd3000;

endpackage

/* hw/rtl/lspc_if.sv */
// ----------------------------------------------------------------------------
// lspc channel interfaces
// Valid/ready channels for button polls, results and configuration words.
// ----------------------------------------------------------------------------
interface lspc_in_if;
  logic        valid;
  logic        ready;
  logic        bank_up_level;
  logic        bank_down_level;
  logic [2:0]  preset_levels;
  logic [3:0]  loop_levels;
  logic [31:0] now_ms;

  modport source (output valid, bank_up_level, bank_down_level, preset_levels,
                  loop_levels, now_ms, input ready);
  modport sink   (input valid, bank_up_level, bank_down_level, preset_levels,
                  loop_levels, now_ms, output ready);
endinterface

interface lspc_out_if;
  logic       valid;
  logic       ready;
  logic [3:0] loop_drive;
  logic [1:0] bank_number;
  logic [1:0] preset_number;
  logic [3:0] program_number;
  logic [1:0] event_code;

  modport source (output valid, loop_drive, bank_number, preset_number,
                  program_number, event_code, input ready);
  modport sink   (input valid, loop_drive, bank_number, preset_number,
                  program_number, event_code, output ready);
endinterface

interface lspc_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [15:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

/* hw/rtl/loop_switcher_preset_controller.sv */
// ----------------------------------------------------------------------------
// loop_switcher_preset_controller: one poll per cycle unless results back up; result registered on acceptance.
// Throughput one poll per clock when output is not stalled; registered store read data is forwarded into drives.
// Synchronous active-low reset: bank 1, preset 1, drives 0, nothing held, debounce 50, long press 3000.
// Preset store cleared at reset by per-entry valid bits; no clearing pass, polls taken at once.
// ----------------------------------------------------------------------------
`include "loop_switcher_preset_controller_defines.svh"

module loop_switcher_preset_controller #(
  parameter int BANK_COUNT = 3
) (
  input  logic     clk,
  input  logic     rst_n,
  lspc_in_if.sink    in_ch,
  lspc_out_if.source out_ch,
  lspc_cfg_if.sink   cfg_ch
);

  import lspc_pkg::*;

  localparam int DEPTH = BANK_COUNT * PRESET_COUNT;
  localparam int AW    = $clog2(DEPTH);
  localparam int BW    = $clog2(BANK_COUNT + 1);

  // --------------------------------------------------------------------------
  // Architectural state. The result word shows this state directly, so the
  // output side only needs a valid flag and the event code.
  // --------------------------------------------------------------------------
  logic [15:0]      debounce_r;
  logic [15:0]      long_press_r;
  logic [3:0]       held_r,    held_nxt;
  logic [31:0]      press_r,   press_nxt;
  logic [BW-1:0]    bank_r,    bank_nxt;
  logic [1:0]       preset_r,  preset_nxt;
  logic [3:0]       drive_r,   drive_nxt;
  logic [1:0]       event_r,   event_nxt;
  logic             out_valid_r;
  // last accepted word loaded drives from the store: the real drives sit in
  // the RAM read register until the next word is accepted
  logic             load_pend_r;
  logic             rd_valid_r;
  logic [DEPTH-1:0] valid_r;

  logic             acc;
  logic             do_load;
  logic             do_save;
  logic             released;
  logic [3:0]       press_code;
  logic [1:0]       pidx;
  logic [1:0]       lidx;
  logic [1:0]       pushed;
  logic [31:0]      hold;
  logic             counted;
  logic             long_hold;
  logic [3:0]       store_q;
  logic [3:0]       drive_cur;
  logic [3:0]       ram_rdata;
  logic [AW-1:0]    raddr;
  logic [AW-1:0]    waddr;
  logic             ram_we;
  logic             ram_re;
  logic [7:0]       prog_full;

  function automatic logic [AW-1:0] slot_of(input logic [BW-1:0] bank,
                                            input logic [1:0] preset);
    logic [AW-1:0] b0;
    logic [AW-1:0] p0;
    b0 = AW'(bank) - AW'(1);
    p0 = AW'(preset) - AW'(1);
    return AW'(b0 * AW'(PRESET_COUNT)) + p0;
  endfunction

  assign acc         = in_ch.valid && in_ch.ready;
  // output register parts the two sides: take a new poll whenever the
  // pending word is empty or leaving this cycle
  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign cfg_ch.ready = 1'b1;

  // forwarded drives: RAM data only changes on an accepted load, so it is
  // stable for as long as the pending flag is set
  assign store_q   = rd_valid_r ? ram_rdata : 4'd0;
  assign drive_cur = load_pend_r ? store_q : drive_r;

  assign hold      = in_ch.now_ms - press_r;
  assign counted   = hold > {16'd0, debounce_r};
  assign long_hold = hold > {16'd0, long_press_r};
  assign pidx      = 2'(held_r - CODE_PRESET0);
  assign lidx      = 2'(held_r - CODE_LOOP0);
  assign pushed    = 2'(held_r - CODE_PRESET0 + 4'd1);

  // new press: later buttons in poll order override earlier ones
  always_comb begin
    press_code = CODE_NONE;
    if (in_ch.bank_up_level)   press_code = CODE_UP;
    if (in_ch.bank_down_level) press_code = CODE_DOWN;
    for (int i = 0; i < PRESET_COUNT; i++) begin
      if (in_ch.preset_levels[i]) press_code = CODE_PRESET0 + 4'(i);
    end
    for (int i = 0; i < LOOP_COUNT; i++) begin
      if (in_ch.loop_levels[i]) press_code = CODE_LOOP0 + 4'(i);
    end
  end

  // held button seen low
  always_comb begin
    case (held_r) inside
      CODE_UP:                          released = !in_ch.bank_up_level;
      CODE_DOWN:                        released = !in_ch.bank_down_level;
      [CODE_PRESET0:CODE_PRESET_LAST]:  released = !in_ch.preset_levels[pidx];
      [CODE_LOOP0:CODE_LOOP_LAST]:      released = !in_ch.loop_levels[lidx];
      default:                          released = 1'b1;
    endcase
  end

  always_comb begin
    held_nxt   = held_r;
    press_nxt  = press_r;
    bank_nxt   = bank_r;
    preset_nxt = preset_r;
    drive_nxt  = drive_cur;
    event_nxt  = EV_NONE;
    do_load    = 1'b0;
    do_save    = 1'b0;
    if (held_r == CODE_NONE) begin
      if (press_code != CODE_NONE) begin
        held_nxt  = press_code;
        press_nxt = in_ch.now_ms;
      end
    end else if (released) begin
      held_nxt = CODE_NONE;
      case (held_r) inside
        CODE_UP: begin
          if (counted) begin
            bank_nxt  = (bank_r == BW'(BANK_COUNT)) ? BW'(1) : bank_r + BW'(1);
            do_load   = 1'b1;
            event_nxt = EV_LOAD;
          end
        end
        CODE_DOWN: begin
          if (counted) begin
            bank_nxt  = (bank_r <= BW'(1)) ? BW'(BANK_COUNT) : bank_r - BW'(1);
            do_load   = 1'b1;
            event_nxt = EV_LOAD;
          end
        end
        [CODE_PRESET0:CODE_PRESET_LAST]: begin
          // long hold saves into the pushed preset's slot of this bank
          if (long_hold) begin
            do_save   = 1'b1;
            event_nxt = EV_SAVE;
          end else if (counted) begin
            preset_nxt = pushed;
            do_load    = 1'b1;
            event_nxt  = EV_LOAD;
          end
        end
        [CODE_LOOP0:CODE_LOOP_LAST]: begin
          if (counted) drive_nxt = drive_cur ^ (4'd1 << lidx);
        end
        default: ;
      endcase
    end
  end

  // save and load never come from the same word, and a save is written
  // before any later word can read, so no same-entry interlock is needed
  assign raddr  = slot_of(bank_nxt, preset_nxt);
  assign waddr  = slot_of(bank_r, pushed);
  assign ram_re = acc && do_load;
  assign ram_we = acc && do_save;

  lspc_ram #(
    .WIDTH (4),
    .DEPTH (DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (waddr),
    .wdata (drive_cur),
    .re    (ram_re),
    .raddr (raddr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      debounce_r   <= DEBOUNCE_RESET;
      long_press_r <= LONG_PRESS_RESET;
      held_r       <= CODE_NONE;
      press_r      <= 32'd0;
      bank_r       <= BW'(1);
      preset_r     <= 2'd1;
      drive_r      <= 4'd0;
      event_r      <= EV_NONE;
      out_valid_r  <= 1'b0;
      load_pend_r  <= 1'b0;
      rd_valid_r   <= 1'b0;
      valid_r      <= '0;
    end else begin
      if (cfg_ch.valid) begin
        if (cfg_ch.index == REG_DEBOUNCE)   debounce_r   <= cfg_ch.data;
        if (cfg_ch.index == REG_LONG_PRESS) long_press_r <= cfg_ch.data;
      end
      if (acc) begin
        held_r      <= held_nxt;
        press_r     <= press_nxt;
        bank_r      <= bank_nxt;
        preset_r    <= preset_nxt;
        drive_r     <= drive_nxt;
        event_r     <= event_nxt;
        load_pend_r <= do_load;
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      if (ram_re) rd_valid_r <= valid_r[raddr];
      if (ram_we) valid_r[waddr] <= 1'b1;
    end
  end

  assign prog_full = 8'((8'(bank_r) - 8'd1) * 8'(PRESET_COUNT)) + 8'(preset_r) - 8'd1;

  assign out_ch.valid          = out_valid_r;
  assign out_ch.loop_drive     = drive_cur;
  assign out_ch.bank_number    = 2'(bank_r);
  assign out_ch.preset_number  = preset_r;
  assign out_ch.program_number = prog_full[3:0];
  assign out_ch.event_code     = event_r;

  // bank selection stays in range
  `LSPC_ASSERT_NOW(a_bank_range, out_valid_r, (bank_r >= BW'(1)) && (bank_r <= BW'(BANK_COUNT)))
  // a word never both saves and loads
  `LSPC_ASSERT_NOW(a_save_load_excl, acc, !(ram_we && ram_re))
  // a store write only comes from a release of a held preset
  `LSPC_ASSERT_NOW(a_save_needs_held, ram_we, (held_r >= CODE_PRESET0) && (held_r <= CODE_PRESET_LAST))
  // a load marks the drives as pending on the RAM read data
  `LSPC_ASSERT_NEXT(a_load_pending, ram_re, load_pend_r && (event_r == EV_LOAD))

endmodule

/* hw/rtl/lspc_ram.sv */
// ----------------------------------------------------------------------------
// lspc_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module lspc_ram #(
  parameter int WIDTH = 4,
  parameter int DEPTH = 9
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule
